>>> rtl/core/prt_pkg.sv
// Package for the pending request table: sizes, codes and shared types.
package prt_pkg;

	// Table depth and derived widths
	localparam int SLOTS = 8;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	// Field widths
	localparam int ADDR_W    = 16;
	localparam int MAC_W     = 64;
	localparam int OPCODE_W  = 8;
	localparam int CLUSTER_W = 16;
	localparam int VALUE_W   = 8;

	// Command codes
	typedef enum logic [1:0] {
		CMD_ISSUE   = 2'd0,
		CMD_RESP    = 2'd1,
		CMD_COLLECT = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_t;

	// Slot phase codes
	typedef enum logic [1:0] {
		PH_FREE     = 2'd0,
		PH_ISSUED   = 2'd1,
		PH_ANSWERED = 2'd2,
		PH_UNUSED   = 2'd3
	} phase_t;

	// Request fields kept per slot
	typedef struct packed {
		logic [ADDR_W-1:0]    addr;
		logic [MAC_W-1:0]     mac;
		logic [OPCODE_W-1:0]  opcode;
		logic [CLUSTER_W-1:0] cluster;
	} slot_req_t;

	// Write controls into the slot store
	typedef struct packed {
		logic             req_we;
		logic             val_we;
		logic [IDX_W-1:0] addr;
	} slot_wr_t;

endpackage

>>> rtl/core/pending_request_table.sv
// Pending request table top level: slot scan sequencer and phase tracking.
//
// Usage: drive command and its fields with start high while busy is low; the
// beat is taken at that edge. Commands: issue fills the lowest free slot,
// response marks the lowest issued slot whose opcode, cluster and address
// match, collect returns and frees the lowest answered slot.
// One result beat per command appears on done_res, out_mac and out_value
// for exactly one cycle with strobe high; the receiver cannot stall it.
// Slots are scanned one per cycle through the shared compare unit behind
// a registered slot read; a scan stops at the first matching slot, and a
// command that finds nothing (or the unused code) scans every slot.
// busy drops in the cycle the result is shown, so the next command can be
// accepted while strobe is high; no command is taken while a scan runs.
// Reset (arst_n low) frees every slot and clears the sequencer; slot data
// is not cleared and is only read after being written.
module pending_request_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    command,
	input  logic [prt_pkg::ADDR_W-1:0]    dest_addr,
	input  logic [prt_pkg::MAC_W-1:0]     node_mac,
	input  logic [prt_pkg::OPCODE_W-1:0]  op_code,
	input  logic [prt_pkg::CLUSTER_W-1:0] cluster_id,
	input  logic [prt_pkg::VALUE_W-1:0]   control_value,
	output logic                          strobe,
	output logic                          done_res,
	output logic [prt_pkg::MAC_W-1:0]     out_mac,
	output logic [prt_pkg::VALUE_W-1:0]   out_value
);
	import prt_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t             state_q;
	cmd_t               cmd_q;
	slot_req_t          req_q;
	logic [VALUE_W-1:0] value_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   idx_s1;
	logic               vld_s1;
	phase_t             phase_q [SLOTS];

	logic               strobe_q;
	logic               done_q;
	logic [MAC_W-1:0]   out_mac_q;
	logic [VALUE_W-1:0] out_value_q;

	slot_wr_t           wr;
	slot_req_t          rd_req;
	logic [VALUE_W-1:0] rd_value;
	logic               rd_en;
	logic               accept;
	logic               hit;
	logic               last;
	phase_t             cur_phase;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign rd_en  = (state_q == ST_SCAN) && (cnt_q < CNT_W'(SLOTS));

	// Shared compare unit: checks the slot read in the previous cycle
	always_comb begin
		cur_phase = phase_q[idx_s1];
		case (cmd_q)
			CMD_ISSUE:   hit = (cur_phase == PH_FREE);
			CMD_RESP:    hit = (cur_phase == PH_ISSUED) &&
				(rd_req.opcode == req_q.opcode) &&
				(rd_req.cluster == req_q.cluster) &&
				(rd_req.addr == req_q.addr);
			CMD_COLLECT: hit = (cur_phase == PH_ANSWERED);
			default:     hit = 1'b0;
		endcase
	end

	assign last = (idx_s1 == IDX_W'(SLOTS - 1));

	// Store writes on a hit
	always_comb begin
		wr.addr   = idx_s1;
		wr.req_we = vld_s1 && hit && (cmd_q == CMD_ISSUE);
		wr.val_we = vld_s1 && hit && (cmd_q == CMD_RESP);
	end

	prt_slot_mem u_mem (
		.clk      (clk),
		.wr       (wr),
		.wr_req   (req_q),
		.wr_value (value_q),
		.rd_en    (rd_en),
		.rd_addr  (cnt_q[IDX_W-1:0]),
		.rd_req   (rd_req),
		.rd_value (rd_value)
	);

	// Sequencer and scan pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
			idx_s1  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					vld_s1 <= 1'b0;
					if (accept) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
					end
				end
				ST_SCAN: begin
					idx_s1 <= cnt_q[IDX_W-1:0];
					vld_s1 <= rd_en;
					if (rd_en) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (vld_s1 && (hit || last)) begin
						state_q <= ST_IDLE;
						vld_s1  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					vld_s1  <= 1'b0;
				end
			endcase
		end
	end

	// Command beat capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q          <= cmd_t'(command);
			req_q.addr     <= dest_addr;
			req_q.mac      <= node_mac;
			req_q.opcode   <= op_code;
			req_q.cluster  <= cluster_id;
			value_q        <= control_value;
		end
	end

	// Slot phases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				phase_q[i] <= PH_FREE;
			end
		end else if (state_q == ST_SCAN && vld_s1 && hit) begin
			case (cmd_q)
				CMD_ISSUE:   phase_q[idx_s1] <= PH_ISSUED;
				CMD_RESP:    phase_q[idx_s1] <= PH_ANSWERED;
				CMD_COLLECT: phase_q[idx_s1] <= PH_FREE;
				default:     phase_q[idx_s1] <= phase_q[idx_s1];
			endcase
		end
	end

	// Result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (state_q == ST_SCAN) && vld_s1 && (hit || last);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && vld_s1 && (hit || last)) begin
			done_q <= hit;
			if (hit && cmd_q == CMD_COLLECT) begin
				out_mac_q   <= rd_req.mac;
				out_value_q <= rd_value;
			end else begin
				out_mac_q   <= '0;
				out_value_q <= '0;
			end
		end
	end

	assign strobe    = strobe_q;
	assign done_res  = done_q;
	assign out_mac   = out_mac_q;
	assign out_value = out_value_q;

	// Result is shown only after the scan has ended
	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> state_q == ST_IDLE)
		else $error("result shown while scanning");

	// Only a collect returns data
	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && cmd_q != CMD_COLLECT |-> out_mac_q == '0 && out_value_q == '0)
		else $error("nonzero data on non-collect result");

	// Compare stage only runs during a scan
	a_vld_scan: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> state_q == ST_SCAN)
		else $error("compare stage valid outside scan");

	// Every accepted command yields a result after the scan
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN ##1 state_q == ST_IDLE |-> strobe_q)
		else $error("scan ended without result");

endmodule

>>> rtl/core/prt_slot_mem.sv
// Slot data store: request fields and control values, registered read.
module prt_slot_mem (
	input  logic                        clk,
	input  prt_pkg::slot_wr_t           wr,
	input  prt_pkg::slot_req_t          wr_req,
	input  logic [prt_pkg::VALUE_W-1:0] wr_value,
	input  logic                        rd_en,
	input  logic [prt_pkg::IDX_W-1:0]   rd_addr,
	output prt_pkg::slot_req_t          rd_req,
	output logic [prt_pkg::VALUE_W-1:0] rd_value
);
	import prt_pkg::*;

	slot_req_t          req_mem [SLOTS];
	logic [VALUE_W-1:0] val_mem [SLOTS];

	// Write port
	always_ff @(posedge clk) begin
		if (wr.req_we) begin
			req_mem[wr.addr] <= wr_req;
		end
		if (wr.val_we) begin
			val_mem[wr.addr] <= wr_value;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_req   <= req_mem[rd_addr];
			rd_value <= val_mem[rd_addr];
		end
	end

endmodule
